// ===== rtl/core/slpg_pkg.sv =====
// Shared types, register codes, colours and reset values for the status LED generator.
package slpg_pkg;

   // Configuration register indexes
   localparam logic [2:0] CSR_BREATHE_PERIOD     = 3'd0;
   localparam logic [2:0] CSR_BREATHE_STEP       = 3'd1;
   localparam logic [2:0] CSR_BREATHE_FLOOR      = 3'd2;
   localparam logic [2:0] CSR_CONFIG_HALF_PERIOD = 3'd3;
   localparam logic [2:0] CSR_ERROR_HALF_PERIOD  = 3'd4;
   localparam logic [2:0] CSR_FLASH_SLOT         = 3'd5;
   localparam logic [2:0] CSR_FLASH_CYCLE        = 3'd6;

   // Configuration reset values
   localparam logic [7:0]  RST_BREATHE_PERIOD     = 8'd20;
   localparam logic [6:0]  RST_BREATHE_STEP       = 7'd2;
   localparam logic [7:0]  RST_BREATHE_FLOOR      = 8'd30;
   localparam logic [11:0] RST_CONFIG_HALF_PERIOD = 12'd500;
   localparam logic [11:0] RST_ERROR_HALF_PERIOD  = 12'd300;
   localparam logic [11:0] RST_FLASH_SLOT         = 12'd200;
   localparam logic [15:0] RST_FLASH_CYCLE        = 16'd2000;

   // Pattern state reset value and saturation limits
   localparam logic [7:0]  RST_BREATHE_LEVEL = 8'd30;
   localparam logic [15:0] ELAPSED_MAX       = 16'hFFFF;
   localparam logic [7:0]  LEVEL_MAX         = 8'd255;

   // Operation codes
   localparam logic OP_TICK   = 1'b0;
   localparam logic OP_CHANGE = 1'b1;

   // Status modes
   localparam logic [2:0] MODE_OFF        = 3'd0;
   localparam logic [2:0] MODE_WAITING    = 3'd1;
   localparam logic [2:0] MODE_CONFIG     = 3'd2;
   localparam logic [2:0] MODE_CONNECTING = 3'd3;
   localparam logic [2:0] MODE_CONNECTED  = 3'd4;
   localparam logic [2:0] MODE_ERROR      = 3'd5;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } colour_type;

   localparam colour_type COL_OFF    = '{red: 8'h00, green: 8'h00, blue: 8'h00};
   localparam colour_type COL_PURPLE = '{red: 8'h80, green: 8'h00, blue: 8'h80};
   localparam colour_type COL_ORANGE = '{red: 8'hFF, green: 8'hA5, blue: 8'h00};
   localparam colour_type COL_GREEN  = '{red: 8'h00, green: 8'h80, blue: 8'h00};
   localparam colour_type COL_RED    = '{red: 8'hFF, green: 8'h00, blue: 8'h00};

   typedef struct packed {
      logic [7:0]  breathe_period;
      logic [6:0]  breathe_step;
      logic [7:0]  breathe_floor;
      logic [11:0] config_half_period;
      logic [11:0] error_half_period;
      logic [11:0] flash_slot;
      logic [15:0] flash_cycle;
   } cfg_type;

   typedef struct packed {
      colour_type colour;
      logic       refresh;
   } result_type;

endpackage

// ===== rtl/core/slpg_csr.sv =====
// Configuration register bank for the status LED generator.
module slpg_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   input  logic [2:0]           csr_index,
   input  logic [15:0]          csr_data,
   output slpg_pkg::cfg_type    cfg
);

   slpg_pkg::cfg_type cfg_ff;
   slpg_pkg::cfg_type cfg_in;

   // Decode the write index and replace the addressed field
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            slpg_pkg::CSR_BREATHE_PERIOD:     cfg_in.breathe_period     = csr_data[7:0];
            slpg_pkg::CSR_BREATHE_STEP:       cfg_in.breathe_step       = csr_data[6:0];
            slpg_pkg::CSR_BREATHE_FLOOR:      cfg_in.breathe_floor      = csr_data[7:0];
            slpg_pkg::CSR_CONFIG_HALF_PERIOD: cfg_in.config_half_period = csr_data[11:0];
            slpg_pkg::CSR_ERROR_HALF_PERIOD:  cfg_in.error_half_period  = csr_data[11:0];
            slpg_pkg::CSR_FLASH_SLOT:         cfg_in.flash_slot         = csr_data[11:0];
            slpg_pkg::CSR_FLASH_CYCLE:        cfg_in.flash_cycle        = csr_data[15:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   // Hold the registers, load defaults on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.breathe_period     <= slpg_pkg::RST_BREATHE_PERIOD;
         cfg_ff.breathe_step       <= slpg_pkg::RST_BREATHE_STEP;
         cfg_ff.breathe_floor      <= slpg_pkg::RST_BREATHE_FLOOR;
         cfg_ff.config_half_period <= slpg_pkg::RST_CONFIG_HALF_PERIOD;
         cfg_ff.error_half_period  <= slpg_pkg::RST_ERROR_HALF_PERIOD;
         cfg_ff.flash_slot         <= slpg_pkg::RST_FLASH_SLOT;
         cfg_ff.flash_cycle        <= slpg_pkg::RST_FLASH_CYCLE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/core/slpg_core.sv =====
// Pattern state and per-transaction next-state logic for the status LED generator.
module slpg_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic                 operation,
   input  logic [2:0]           status,
   input  slpg_pkg::cfg_type    cfg,
   output slpg_pkg::result_type result
);

   logic [2:0]           mode_ff, mode_in;
   logic [15:0]          elapsed_ff, elapsed_in;
   slpg_pkg::colour_type colour_ff, colour_in;
   logic [7:0]           level_ff, level_in;
   logic                 rising_ff, rising_in;
   logic                 cfg_blink_ff, cfg_blink_in;
   logic                 err_blink_ff, err_blink_in;
   logic                 refresh;

   logic [15:0] elapsed_inc;
   logic [8:0]  rise_sum;
   logic [8:0]  fall_limit;
   logic [7:0]  level_step;
   logic        level_step_rising;
   logic [16:0] e_wide;
   logic [16:0] slot_1x;
   logic [16:0] slot_2x;
   logic [16:0] slot_3x;

   // Saturating elapsed count and breathing step
   always_comb begin
      elapsed_inc = (elapsed_ff == slpg_pkg::ELAPSED_MAX) ? elapsed_ff : elapsed_ff + 16'd1;
      rise_sum    = {1'b0, level_ff} + {2'b00, cfg.breathe_step};
      fall_limit  = {1'b0, cfg.breathe_floor} + {2'b00, cfg.breathe_step};
      if (rising_ff) begin
         if (rise_sum >= {1'b0, slpg_pkg::LEVEL_MAX}) begin
            level_step        = slpg_pkg::LEVEL_MAX;
            level_step_rising = 1'b0;
         end else begin
            level_step        = rise_sum[7:0];
            level_step_rising = 1'b1;
         end
      end else begin
         if ({1'b0, level_ff} <= fall_limit) begin
            level_step        = cfg.breathe_floor;
            level_step_rising = 1'b1;
         end else begin
            level_step        = level_ff - {1'b0, cfg.breathe_step};
            level_step_rising = 1'b0;
         end
      end
      e_wide  = {1'b0, elapsed_inc};
      slot_1x = {5'd0, cfg.flash_slot};
      slot_2x = {4'd0, cfg.flash_slot, 1'b0};
      slot_3x = slot_2x + slot_1x;
   end

   // Next state for one transaction
   always_comb begin
      mode_in      = mode_ff;
      elapsed_in   = elapsed_ff;
      colour_in    = colour_ff;
      level_in     = level_ff;
      rising_in    = rising_ff;
      cfg_blink_in = cfg_blink_ff;
      err_blink_in = err_blink_ff;
      refresh      = 1'b0;
      if (operation == slpg_pkg::OP_CHANGE) begin
         mode_in    = status;
         elapsed_in = '0;
         level_in   = cfg.breathe_floor;
         rising_in  = 1'b1;
      end else begin
         elapsed_in = elapsed_inc;
         case (mode_ff)
            slpg_pkg::MODE_WAITING: begin
               if (elapsed_inc >= {8'd0, cfg.breathe_period}) begin
                  level_in   = level_step;
                  rising_in  = level_step_rising;
                  colour_in  = '{red: 8'h00, green: 8'h00, blue: level_step};
                  refresh    = 1'b1;
                  elapsed_in = '0;
               end
            end
            slpg_pkg::MODE_CONFIG: begin
               if (elapsed_inc >= {4'd0, cfg.config_half_period}) begin
                  cfg_blink_in = !cfg_blink_ff;
                  colour_in    = cfg_blink_ff ? slpg_pkg::COL_OFF : slpg_pkg::COL_PURPLE;
                  refresh      = 1'b1;
                  elapsed_in   = '0;
               end
            end
            slpg_pkg::MODE_CONNECTING: begin
               colour_in = slpg_pkg::COL_ORANGE;
               refresh   = 1'b1;
            end
            slpg_pkg::MODE_CONNECTED: begin
               if (e_wide < slot_1x) begin
                  colour_in = slpg_pkg::COL_GREEN;
                  refresh   = 1'b1;
               end else if (e_wide < slot_2x) begin
                  colour_in = slpg_pkg::COL_OFF;
                  refresh   = 1'b1;
               end else if (e_wide < slot_3x) begin
                  colour_in = slpg_pkg::COL_GREEN;
                  refresh   = 1'b1;
               end else if (elapsed_inc < cfg.flash_cycle) begin
                  colour_in = slpg_pkg::COL_OFF;
                  refresh   = 1'b1;
               end else begin
                  // End of sequence: restart timing, keep the colour
                  elapsed_in = '0;
               end
            end
            slpg_pkg::MODE_ERROR: begin
               if (elapsed_inc >= {4'd0, cfg.error_half_period}) begin
                  err_blink_in = !err_blink_ff;
                  colour_in    = err_blink_ff ? slpg_pkg::COL_OFF : slpg_pkg::COL_RED;
                  refresh      = 1'b1;
                  elapsed_in   = '0;
               end
            end
            default: begin
               // Off and the unused status codes
               colour_in = slpg_pkg::COL_OFF;
               refresh   = 1'b1;
            end
         endcase
      end
   end

   // Advance state on each accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= slpg_pkg::MODE_OFF;
         elapsed_ff   <= '0;
         colour_ff    <= slpg_pkg::COL_OFF;
         level_ff     <= slpg_pkg::RST_BREATHE_LEVEL;
         rising_ff    <= 1'b1;
         cfg_blink_ff <= 1'b0;
         err_blink_ff <= 1'b0;
      end else if (accept) begin
         mode_ff      <= mode_in;
         elapsed_ff   <= elapsed_in;
         colour_ff    <= colour_in;
         level_ff     <= level_in;
         rising_ff    <= rising_in;
         cfg_blink_ff <= cfg_blink_in;
         err_blink_ff <= err_blink_in;
      end
   end

   assign result.colour  = colour_in;
   assign result.refresh = refresh;

endmodule

// ===== rtl/core/slpg_out_stage.sv =====
// Result register and output handshake for the status LED generator.
module slpg_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  slpg_pkg::result_type result,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic                 space,
   output slpg_pkg::result_type rsp_data
);

   logic                 valid_ff, valid_in;
   slpg_pkg::result_type data_ff;

   // Free when empty or being drained this cycle
   assign space = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Capture the payload of a new transaction
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// ===== rtl/core/status_led_pattern_generator.sv =====
// Top level of the status LED pattern generator.
// Each request is a 1 ms tick or a status change; every accepted request yields one
// response with the held RGB colour and a refresh flag, shown in the cycle after acceptance.
// One request is taken per clock while there is space: the pattern state updates
// on each acceptance and a single result register holds the response, so req_ready
// is high whenever that register is empty or being read in the same cycle.
// Configuration writes are always accepted and take effect on the next cycle.
module status_led_pattern_generator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_operation,
   input  logic [2:0]  req_status,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic        rsp_refresh,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   slpg_pkg::cfg_type    cfg;
   slpg_pkg::result_type result;
   slpg_pkg::result_type rsp_data;
   logic                 space;
   logic                 accept;

   assign csr_ready = 1'b1;
   assign req_ready = space;
   assign accept    = req_valid && space;

   slpg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   slpg_core u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .operation (req_operation),
      .status    (req_status),
      .cfg       (cfg),
      .result    (result)
   );

   slpg_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .result    (result),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .space     (space),
      .rsp_data  (rsp_data)
   );

   assign rsp_red     = rsp_data.colour.red;
   assign rsp_green   = rsp_data.colour.green;
   assign rsp_blue    = rsp_data.colour.blue;
   assign rsp_refresh = rsp_data.refresh;

endmodule

// ===== rtl/core/slpg_checker.sv =====
// Port-level assertions for the status LED generator, bound to the top level.
module slpg_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_operation,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_red,
   input logic [7:0]  rsp_green,
   input logic        rsp_refresh
);

   // Every accepted transaction shows a response on the next cycle
   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> rsp_valid)
      else $error("accepted request produced no response");

   // A status change never rewrites the colour
   a_change_no_refresh: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_operation) |=> !rsp_refresh)
      else $error("status change flagged a refresh");

   // Only palette values appear on the green and red channels
   a_palette: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_green == 8'h00 || rsp_green == 8'h80 || rsp_green == 8'hA5) &&
                     (rsp_red == 8'h00 || rsp_red == 8'h80 || rsp_red == 8'hFF)))
      else $error("colour outside the palette");

   // A stalled response holds its valid, red channel and refresh flag
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_red) && $stable(rsp_refresh)))
      else $error("stalled response changed");

endmodule

bind status_led_pattern_generator slpg_checker u_slpg_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_operation (req_operation),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_red       (rsp_red),
   .rsp_green     (rsp_green),
   .rsp_refresh   (rsp_refresh)
);

// ===== dv/status_led_pattern_generator_tb.sv =====
// Self-checking testbench for the status LED pattern generator: predictor, driver and monitor.
`timescale 1ns / 100ps

module status_led_pattern_generator_tb;

   localparam int          WATCHDOG_LIMIT = 1000;
   localparam int          DRAIN_CYCLES   = 5;
   localparam int          CALM_START     = 300;
   localparam int          CALM_END       = 520;
   localparam logic [2:0]  CSR_UNUSED     = 3'd7;
   localparam logic [2:0]  MODE_SPARE_LO  = 3'd6;
   localparam logic [2:0]  MODE_SPARE_HI  = 3'd7;

   typedef struct packed {
      logic       operation;
      logic [2:0] status;
   } led_request_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_operation = slpg_pkg::OP_TICK;
   logic [2:0]  req_status = slpg_pkg::MODE_OFF;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_red;
   logic [7:0]  rsp_green;
   logic [7:0]  rsp_blue;
   logic        rsp_refresh;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = slpg_pkg::CSR_BREATHE_PERIOD;
   logic [15:0] csr_data = '0;

   status_led_pattern_generator dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_status    (req_status),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_red       (rsp_red),
      .rsp_green     (rsp_green),
      .rsp_blue      (rsp_blue),
      .rsp_refresh   (rsp_refresh),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   always #5 clock = ~clock;

   // Shadow of the pattern state and the registers
   slpg_pkg::cfg_type    led_cfg;
   logic [2:0]           led_mode;
   logic [15:0]          ms_elapsed;
   slpg_pkg::colour_type held_colour;
   logic [7:0]           breathe_lvl;
   logic                 breathe_up;
   logic                 purple_on;
   logic                 red_on;

   led_request_type      pending_requests[$];
   slpg_pkg::result_type led_expected[$];
   int                   mismatches = 0;
   int                   responses_seen = 0;
   int                   cycle_count = 0;
   int                   idle_cycles = 0;

   // Work out the held colour and refresh flag that one transaction leaves behind
   function automatic slpg_pkg::result_type predict_led(logic op, logic [2:0] st);
      slpg_pkg::result_type res;
      int         e;
      int         lvl;
      int         slot;
      res.refresh = 1'b0;
      if (op == slpg_pkg::OP_CHANGE) begin
         led_mode    = st;
         ms_elapsed  = '0;
         breathe_lvl = led_cfg.breathe_floor;
         breathe_up  = 1'b1;
      end else begin
         if (ms_elapsed < slpg_pkg::ELAPSED_MAX) ms_elapsed = ms_elapsed + 16'd1;
         e    = int'(ms_elapsed);
         slot = int'(led_cfg.flash_slot);
         case (led_mode)
            slpg_pkg::MODE_WAITING: begin
               if (e >= int'(led_cfg.breathe_period)) begin
                  if (breathe_up) begin
                     lvl = int'(breathe_lvl) + int'(led_cfg.breathe_step);
                     // clamp at full scale rather than wrapping
                     if (lvl >= int'(slpg_pkg::LEVEL_MAX)) begin
                        lvl        = int'(slpg_pkg::LEVEL_MAX);
                        breathe_up = 1'b0;
                     end
                  end else begin
                     lvl = int'(breathe_lvl) - int'(led_cfg.breathe_step);
                     if (lvl <= int'(led_cfg.breathe_floor)) begin
                        lvl        = int'(led_cfg.breathe_floor);
                        breathe_up = 1'b1;
                     end
                  end
                  breathe_lvl      = lvl[7:0];
                  held_colour      = slpg_pkg::COL_OFF;
                  held_colour.blue = breathe_lvl;
                  res.refresh      = 1'b1;
                  ms_elapsed       = '0;
               end
            end
            slpg_pkg::MODE_CONFIG: begin
               if (e >= int'(led_cfg.config_half_period)) begin
                  purple_on   = ~purple_on;
                  held_colour = purple_on ? slpg_pkg::COL_PURPLE : slpg_pkg::COL_OFF;
                  res.refresh = 1'b1;
                  ms_elapsed  = '0;
               end
            end
            slpg_pkg::MODE_CONNECTING: begin
               held_colour = slpg_pkg::COL_ORANGE;
               res.refresh = 1'b1;
            end
            slpg_pkg::MODE_CONNECTED: begin
               if (e < slot) begin
                  held_colour = slpg_pkg::COL_GREEN;
                  res.refresh = 1'b1;
               end else if (e < 2 * slot) begin
                  held_colour = slpg_pkg::COL_OFF;
                  res.refresh = 1'b1;
               end else if (e < 3 * slot) begin
                  held_colour = slpg_pkg::COL_GREEN;
                  res.refresh = 1'b1;
               end else if (e < int'(led_cfg.flash_cycle)) begin
                  held_colour = slpg_pkg::COL_OFF;
                  res.refresh = 1'b1;
               end else begin
                  // end of the flash sequence: restart without a rewrite
                  ms_elapsed = '0;
               end
            end
            slpg_pkg::MODE_ERROR: begin
               if (e >= int'(led_cfg.error_half_period)) begin
                  red_on      = ~red_on;
                  held_colour = red_on ? slpg_pkg::COL_RED : slpg_pkg::COL_OFF;
                  res.refresh = 1'b1;
                  ms_elapsed  = '0;
               end
            end
            default: begin
               held_colour = slpg_pkg::COL_OFF;
               res.refresh = 1'b1;
            end
         endcase
      end
      res.colour = held_colour;
      return res;
   endfunction

   // Mirror a register write into the shadow configuration
   function automatic void shadow_csr(logic [2:0] idx, logic [15:0] data);
      case (idx)
         slpg_pkg::CSR_BREATHE_PERIOD:     led_cfg.breathe_period     = data[7:0];
         slpg_pkg::CSR_BREATHE_STEP:       led_cfg.breathe_step       = data[6:0];
         slpg_pkg::CSR_BREATHE_FLOOR:      led_cfg.breathe_floor      = data[7:0];
         slpg_pkg::CSR_CONFIG_HALF_PERIOD: led_cfg.config_half_period = data[11:0];
         slpg_pkg::CSR_ERROR_HALF_PERIOD:  led_cfg.error_half_period  = data[11:0];
         slpg_pkg::CSR_FLASH_SLOT:         led_cfg.flash_slot         = data[11:0];
         slpg_pkg::CSR_FLASH_CYCLE:        led_cfg.flash_cycle        = data;
         default: ;
      endcase
   endfunction

   function automatic bit take_break();
      if (cycle_count >= CALM_START && cycle_count < CALM_END) return 1'b0;
      return $urandom_range(99) < 12;
   endfunction

   task automatic report_mismatch(string msg);
      $display("MISMATCH at response %0d: %s", responses_seen, msg);
      mismatches++;
   endtask

   task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
   endtask

   initial begin
      led_cfg = '{breathe_period: slpg_pkg::RST_BREATHE_PERIOD,
                  breathe_step: slpg_pkg::RST_BREATHE_STEP,
                  breathe_floor: slpg_pkg::RST_BREATHE_FLOOR,
                  config_half_period: slpg_pkg::RST_CONFIG_HALF_PERIOD,
                  error_half_period: slpg_pkg::RST_ERROR_HALF_PERIOD,
                  flash_slot: slpg_pkg::RST_FLASH_SLOT,
                  flash_cycle: slpg_pkg::RST_FLASH_CYCLE};
      led_mode    = slpg_pkg::MODE_OFF;
      ms_elapsed  = '0;
      held_colour = slpg_pkg::COL_OFF;
      breathe_lvl = slpg_pkg::RST_BREATHE_LEVEL;
      breathe_up  = 1'b1;
      purple_on   = 1'b0;
      red_on      = 1'b0;
   end

   // Driver: present queued requests, predict each accepted transaction
   always @(posedge clock) begin : drive_requests
      led_request_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            led_expected.push_back(predict_led(req_operation, req_status));
         if (!req_valid || req_ready) begin
            if (pending_requests.size() != 0 && !take_break()) begin
               nxt = pending_requests.pop_front();
               req_valid     <= 1'b1;
               req_operation <= nxt.operation;
               req_status    <= nxt.status;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each response with the oldest prediction
   always @(posedge clock) begin : watch_responses
      slpg_pkg::result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (led_expected.size() == 0) begin
               report_mismatch("response with nothing expected");
            end else begin
               want = led_expected.pop_front();
               check_field("red", rsp_red, want.colour.red);
               check_field("green", rsp_green, want.colour.green);
               check_field("blue", rsp_blue, want.colour.blue);
               check_field("refresh", {7'd0, rsp_refresh}, {7'd0, want.refresh});
            end
            responses_seen++;
         end
         rsp_ready <= !take_break();
      end
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired after %0d idle cycles", idle_cycles);
            $display("status_led_pattern_generator_tb: errors");
            $finish;
         end
      end
   end

   task automatic csr_write(logic [2:0] idx, logic [15:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      shadow_csr(idx, data);
      csr_valid <= 1'b0;
   endtask

   // Write every register, with junk in the bits above each field narrower than the data bus
   task automatic apply_settings(logic [7:0] period, logic [6:0] step, logic [7:0] floor_lvl,
                                 logic [11:0] cfg_half, logic [11:0] err_half,
                                 logic [11:0] slot, logic [15:0] cycle_len);
      logic [15:0] junk;
      junk = 16'($urandom);
      csr_write(slpg_pkg::CSR_BREATHE_PERIOD, {junk[15:8], period});
      csr_write(slpg_pkg::CSR_BREATHE_STEP, {junk[8:0], step});
      csr_write(slpg_pkg::CSR_BREATHE_FLOOR, {junk[7:0], floor_lvl});
      csr_write(slpg_pkg::CSR_CONFIG_HALF_PERIOD, {junk[3:0], cfg_half});
      csr_write(slpg_pkg::CSR_ERROR_HALF_PERIOD, {junk[11:8], err_half});
      csr_write(slpg_pkg::CSR_FLASH_SLOT, {junk[15:12], slot});
      csr_write(slpg_pkg::CSR_FLASH_CYCLE, cycle_len);
      @(negedge clock);
   endtask

   task automatic random_settings();
      logic [7:0]  period;
      logic [6:0]  step;
      logic [11:0] cfg_half;
      logic [11:0] err_half;
      logic [11:0] slot;
      logic [15:0] cycle_len;
      case ($urandom_range(9))
         0:       period = 8'd0;
         1:       period = 8'd255;
         default: period = 8'($urandom_range(1, 8));
      endcase
      case ($urandom_range(9))
         0:       step = 7'd0;
         1:       step = 7'd127;
         default: step = 7'($urandom_range(1, 127));
      endcase
      case ($urandom_range(9))
         0:       cfg_half = 12'd0;
         1:       cfg_half = 12'd4095;
         default: cfg_half = 12'($urandom_range(1, 8));
      endcase
      case ($urandom_range(9))
         0:       err_half = 12'd0;
         1:       err_half = 12'd4095;
         default: err_half = 12'($urandom_range(1, 8));
      endcase
      case ($urandom_range(9))
         0:       slot = 12'd0;
         1:       slot = 12'd4095;
         default: slot = 12'($urandom_range(1, 5));
      endcase
      case ($urandom_range(9))
         0:       cycle_len = 16'd0;
         1:       cycle_len = 16'hFFFF;
         default: cycle_len = 16'($urandom_range(1, 40));
      endcase
      apply_settings(period, step, 8'($urandom_range(255)), cfg_half, err_half, slot,
                     cycle_len);
   endtask

   task automatic push_request(logic op, logic [2:0] st);
      pending_requests.push_back('{operation: op, status: st});
   endtask

   task automatic push_ticks(int n);
      repeat (n) push_request(slpg_pkg::OP_TICK, slpg_pkg::MODE_OFF);
   endtask

   // Mostly a status change followed by a run of ticks, the rest loose noise
   task automatic fill_random_phase(int count);
      int          queued;
      int          run;
      logic [2:0]  st;
      queued = 0;
      while (queued < count) begin
         if ($urandom_range(99) < 80) begin
            st  = ($urandom_range(9) < 8) ? 3'($urandom_range(1, 5)) : 3'($urandom_range(7));
            run = $urandom_range(1, 30);
            push_request(slpg_pkg::OP_CHANGE, st);
            push_ticks(run);
            queued += run + 1;
         end else begin
            push_request(1'($urandom_range(1)), 3'($urandom_range(7)));
            queued++;
         end
      end
   endtask

   // Hold until every request is taken and every response checked
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_requests.size() != 0 || req_valid || led_expected.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Every mode once at reset settings, including the two unused codes
      push_ticks(1);
      push_request(slpg_pkg::OP_CHANGE, slpg_pkg::MODE_CONNECTING);
      push_ticks(1);
      push_request(slpg_pkg::OP_CHANGE, MODE_SPARE_LO);
      push_ticks(1);
      push_request(slpg_pkg::OP_CHANGE, MODE_SPARE_HI);
      push_ticks(1);
      push_request(slpg_pkg::OP_CHANGE, slpg_pkg::MODE_WAITING);
      push_ticks(1);
      push_request(slpg_pkg::OP_CHANGE, slpg_pkg::MODE_CONNECTED);
      push_ticks(1);
      push_request(slpg_pkg::OP_CHANGE, slpg_pkg::MODE_CONFIG);
      push_request(slpg_pkg::OP_CHANGE, slpg_pkg::MODE_ERROR);
      push_ticks(1);
      wait_drained();

      // Zero period, step, half periods, slot and cycle, floor at full scale, after an unused-index write
      csr_write(CSR_UNUSED, 16'hFFFF);
      apply_settings(8'd0, 7'd0, 8'd255, 12'd0, 12'd0, 12'd0, 16'd0);
      push_request(slpg_pkg::OP_CHANGE, slpg_pkg::MODE_WAITING);
      push_ticks(2);
      push_request(slpg_pkg::OP_CHANGE, slpg_pkg::MODE_CONFIG);
      push_ticks(1);
      push_request(slpg_pkg::OP_CHANGE, slpg_pkg::MODE_CONNECTED);
      push_ticks(1);
      wait_drained();

      // Rising past full scale clamps, then falls straight back to the floor
      apply_settings(8'd1, 7'd64, 8'd250, 12'd1, 12'd1, 12'd1, 16'd3);
      push_request(slpg_pkg::OP_CHANGE, slpg_pkg::MODE_WAITING);
      push_ticks(2);
      wait_drained();

      repeat (4) begin
         random_settings();
         fill_random_phase(70);
         wait_drained();
      end

      // Longest settings: no phase expires, steady patterns still rewrite
      apply_settings(8'd255, 7'd127, 8'd200, 12'd4095, 12'd4095, 12'd4095, 16'hFFFF);
      push_request(slpg_pkg::OP_CHANGE, slpg_pkg::MODE_CONFIG);
      push_ticks(10);
      push_request(slpg_pkg::OP_CHANGE, slpg_pkg::MODE_ERROR);
      push_ticks(10);
      push_request(slpg_pkg::OP_CHANGE, slpg_pkg::MODE_WAITING);
      push_ticks(10);
      push_request(slpg_pkg::OP_CHANGE, slpg_pkg::MODE_CONNECTED);
      push_ticks(10);
      push_request(slpg_pkg::OP_CHANGE, slpg_pkg::MODE_CONNECTING);
      push_ticks(10);
      wait_drained();

      if (led_expected.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", led_expected.size()));
      if (mismatches == 0)
         $display("status_led_pattern_generator_tb: clean");
      else
         $display("status_led_pattern_generator_tb: errors");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/slpg_pkg.sv
rtl/core/slpg_csr.sv
rtl/core/slpg_core.sv
rtl/core/slpg_out_stage.sv
rtl/core/status_led_pattern_generator.sv
rtl/core/slpg_checker.sv
dv/status_led_pattern_generator_tb.sv
